// File: hw/rtl/kle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_pkg
// Shared constants, codes and types of the keystroke line editor.
// ----------------------------------------------------------------------------
package kle_pkg;

   localparam int LINE_DEPTH = 32;
   localparam int ADDR_W     = $clog2(LINE_DEPTH);
   localparam int KEY_W      = 8;
   localparam int POS_W      = 6;
   localparam int COL_W      = 9;
   localparam int STAT_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int ALU_W      = 9;

   localparam logic [KEY_W-1:0] KEY_ENTER  = 8'd13;
   localparam logic [KEY_W-1:0] KEY_ESCAPE = 8'd27;
   localparam logic [KEY_W-1:0] KEY_LEFT   = 8'd75;
   localparam logic [KEY_W-1:0] KEY_RIGHT  = 8'd77;
   localparam logic [KEY_W-1:0] KEY_HOME   = 8'd71;
   localparam logic [KEY_W-1:0] KEY_END    = 8'd79;
   localparam logic [KEY_W-1:0] KEY_DOT    = 8'd46;
   localparam logic [KEY_W-1:0] KEY_SPACE  = 8'd32;

   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_LOW    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_COLUMN = 2'd2;

   localparam logic [KEY_W-1:0] RANGE_LOW_RESET    = 8'd48;
   localparam logic [KEY_W-1:0] RANGE_HIGH_RESET   = 8'd57;
   localparam logic [KEY_W-1:0] START_COLUMN_RESET = 8'd0;

   typedef enum logic [STAT_W-1:0] {
      ST_ACCEPTED  = 3'd0,
      ST_MOVED     = 3'd1,
      ST_IGNORED   = 3'd2,
      ST_LINE_CHAR = 3'd3,
      ST_LINE_END  = 3'd4,
      ST_ABORTED   = 3'd5,
      ST_FULL      = 3'd6
   } status_type;

   typedef struct packed {
      logic [KEY_W-1:0] range_low;
      logic [KEY_W-1:0] range_high;
      logic [KEY_W-1:0] start_column;
   } csr_type;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             carry;
   } alu_rsp_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [KEY_W-1:0]  data;
   } ram_wr_type;

   typedef struct packed {
      logic              load;
      status_type        status;
      logic [KEY_W-1:0]  char_out;
      logic [POS_W-1:0]  cursor_index;
      logic [COL_W-1:0]  cursor_column;
      logic              is_last;
   } push_type;

endpackage

// File: hw/rtl/kle_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_alu
// Shared add and subtract unit used for range compares, cursor steps,
// column sums and the read index of the line buffer.
// ----------------------------------------------------------------------------
module kle_alu (
   input  kle_pkg::alu_req_type alu_req,
   output kle_pkg::alu_rsp_type alu_rsp
);
   import kle_pkg::*;

   logic [ALU_W-1:0] operand_b;
   logic [ALU_W:0]   total;

   assign operand_b = alu_req.sub ? ~alu_req.b : alu_req.b;
   assign total     = {1'b0, alu_req.a} + {1'b0, operand_b} + {{ALU_W{1'b0}}, alu_req.sub};

   // For a subtraction the carry is set when no borrow occurs, that is a >= b.
   assign alu_rsp.sum   = total[ALU_W-1:0];
   assign alu_rsp.carry = total[ALU_W];

endmodule

// File: hw/rtl/kle_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_line_ram
// Line buffer: one write port and one registered read port.
// ----------------------------------------------------------------------------
module kle_line_ram (
   input  logic                        clock,
   input  kle_pkg::ram_wr_type         ram_wr,
   input  logic                        rd_en,
   input  logic [kle_pkg::ADDR_W-1:0]  rd_addr,
   output logic [kle_pkg::KEY_W-1:0]   rd_data
);
   import kle_pkg::*;

   logic [KEY_W-1:0] mem_ff [LINE_DEPTH];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_wr.en) begin
         mem_ff[ram_wr.addr] <= ram_wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/kle_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_sequencer
// Steps one key through range checks, cursor update and column sum on the
// shared unit, then streams the stored line on enter.
// ----------------------------------------------------------------------------
module kle_sequencer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [kle_pkg::KEY_W-1:0]   req_key_code,
   output logic                        req_ready,
   input  kle_pkg::csr_type            csr,
   output kle_pkg::alu_req_type        alu_req,
   input  kle_pkg::alu_rsp_type        alu_rsp,
   output kle_pkg::ram_wr_type         ram_wr,
   output logic                        ram_rd_en,
   output logic [kle_pkg::ADDR_W-1:0]  ram_rd_addr,
   input  logic [kle_pkg::KEY_W-1:0]   ram_rd_data,
   input  logic                        rsp_free,
   output kle_pkg::push_type           push
);
   import kle_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE      = 8'b0000_0001,
      S_CMP_LO    = 8'b0000_0010,
      S_CMP_HI    = 8'b0000_0100,
      S_STEP      = 8'b0000_1000,
      S_COLUMN    = 8'b0001_0000,
      S_READ      = 8'b0010_0000,
      S_PUSH_CHAR = 8'b0100_0000,
      S_PUSH_LAST = 8'b1000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             ge_lo_ff, ge_lo_in;
   logic             accept_ff, accept_in;
   logic [POS_W-1:0] cursor_ff, cursor_in;
   logic [POS_W-1:0] length_ff, length_in;
   logic [POS_W-1:0] emit_len_ff, emit_len_in;
   logic [POS_W-1:0] idx_ff, idx_in;
   logic [COL_W-1:0] column_ff, column_in;
   status_type       status_ff, status_in;
   logic [KEY_W-1:0] char_ff, char_in;
   logic             is_enter;
   logic             is_escape;
   logic             is_left;
   logic             is_right;
   logic             is_home;
   logic             is_end;

   assign is_enter  = (key_ff == KEY_ENTER);
   assign is_escape = (key_ff == KEY_ESCAPE);
   assign is_left   = (key_ff == KEY_LEFT);
   assign is_right  = (key_ff == KEY_RIGHT);
   assign is_home   = (key_ff == KEY_HOME);
   assign is_end    = (key_ff == KEY_END);

   assign req_ready   = (state_ff == S_IDLE);
   assign ram_rd_en   = (state_ff == S_READ);
   assign ram_rd_addr = idx_ff[ADDR_W-1:0];

   always_comb begin
      alu_req = '0;
      case (state_ff)
         S_CMP_LO: begin
            alu_req.a   = {1'b0, key_ff};
            alu_req.b   = {1'b0, csr.range_low};
            alu_req.sub = 1'b1;
         end
         S_CMP_HI: begin
            alu_req.a   = {1'b0, csr.range_high};
            alu_req.b   = {1'b0, key_ff};
            alu_req.sub = 1'b1;
         end
         S_STEP: begin
            alu_req.a   = {{(ALU_W-POS_W){1'b0}}, cursor_ff};
            alu_req.b   = ALU_W'(1);
            alu_req.sub = is_left;
         end
         S_COLUMN: begin
            alu_req.a = {1'b0, csr.start_column};
            alu_req.b = {{(ALU_W-POS_W){1'b0}}, cursor_ff};
         end
         S_PUSH_CHAR: begin
            alu_req.a = {{(ALU_W-POS_W){1'b0}}, idx_ff};
            alu_req.b = ALU_W'(1);
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      key_in      = key_ff;
      ge_lo_in    = ge_lo_ff;
      accept_in   = accept_ff;
      cursor_in   = cursor_ff;
      length_in   = length_ff;
      emit_len_in = emit_len_ff;
      idx_in      = idx_ff;
      column_in   = column_ff;
      status_in   = status_ff;
      char_in     = char_ff;
      ram_wr.en   = 1'b0;
      ram_wr.addr = cursor_ff[ADDR_W-1:0];
      ram_wr.data = key_ff;
      push.load          = 1'b0;
      push.status        = status_ff;
      push.char_out      = char_ff;
      push.cursor_index  = cursor_ff;
      push.cursor_column = column_ff;
      push.is_last       = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               key_in   = req_key_code;
               state_in = S_CMP_LO;
            end
         end
         S_CMP_LO: begin
            ge_lo_in = alu_rsp.carry;
            state_in = S_CMP_HI;
         end
         S_CMP_HI: begin
            accept_in = (ge_lo_ff && alu_rsp.carry) || (key_ff == KEY_DOT)
                        || (key_ff == KEY_SPACE);
            state_in  = S_STEP;
         end
         S_STEP: begin
            char_in  = '0;
            state_in = S_COLUMN;
            if (is_enter) begin
               status_in   = ST_LINE_END;
               emit_len_in = length_ff;
               cursor_in   = '0;
               length_in   = '0;
            end else if (is_escape) begin
               status_in = ST_ABORTED;
               cursor_in = '0;
               length_in = '0;
            end else if (is_left) begin
               status_in = ST_MOVED;
               if (cursor_ff != '0) begin
                  cursor_in = alu_rsp.sum[POS_W-1:0];
               end
            end else if (is_right) begin
               status_in = ST_MOVED;
               if (cursor_ff != length_ff) begin
                  cursor_in = alu_rsp.sum[POS_W-1:0];
               end
            end else if (is_home) begin
               status_in = ST_MOVED;
               cursor_in = '0;
            end else if (is_end) begin
               status_in = ST_MOVED;
               cursor_in = length_ff;
            end else if (!accept_ff) begin
               status_in = ST_IGNORED;
            end else if (cursor_ff == POS_W'(LINE_DEPTH)) begin
               status_in = ST_FULL;
            end else begin
               status_in = ST_ACCEPTED;
               char_in   = key_ff;
               ram_wr.en = 1'b1;
               cursor_in = alu_rsp.sum[POS_W-1:0];
               if (cursor_ff == length_ff) begin
                  length_in = alu_rsp.sum[POS_W-1:0];
               end
            end
         end
         S_COLUMN: begin
            column_in = alu_rsp.sum[COL_W-1:0];
            idx_in    = '0;
            if (is_enter && (emit_len_ff != '0)) begin
               state_in = S_READ;
            end else begin
               state_in = S_PUSH_LAST;
            end
         end
         S_READ: begin
            state_in = S_PUSH_CHAR;
         end
         S_PUSH_CHAR: begin
            push.status   = ST_LINE_CHAR;
            push.char_out = ram_rd_data;
            push.is_last  = 1'b0;
            if (rsp_free) begin
               push.load = 1'b1;
               idx_in    = alu_rsp.sum[POS_W-1:0];
               if (alu_rsp.sum[POS_W-1:0] == emit_len_ff) begin
                  state_in = S_PUSH_LAST;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_PUSH_LAST: begin
            if (rsp_free) begin
               push.load = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cursor_ff <= '0;
         length_ff <= '0;
      end else begin
         state_ff  <= state_in;
         cursor_ff <= cursor_in;
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      ge_lo_ff    <= ge_lo_in;
      accept_ff   <= accept_in;
      emit_len_ff <= emit_len_in;
      idx_ff      <= idx_in;
      column_ff   <= column_in;
      status_ff   <= status_in;
      char_ff     <= char_in;
   end

endmodule

// File: hw/rtl/keystroke_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keystroke_line_editor
// Line editor with cursor, driven by one key code per item.
//
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_ready   key code
// rsp_      out        rsp_valid/rsp_ready   status, character, cursor, column, last
// csr_      in         csr_wr_en             register index and data
//
// An ordinary key passes the low and high range compares, the cursor step and the
// column sum before its result is pushed, and the editor takes no new key until that push.
// Enter adds one line buffer read and one push for each stored character.
// This order comes from the sequencer stepping each key through the shared adder.
// Reset is synchronous and clears cursor, line length, sequencer and result valid, and loads the register defaults.
// A stalled result holds the sequencer at its push step; no item is lost.
// ----------------------------------------------------------------------------
module keystroke_line_editor (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [kle_pkg::KEY_W-1:0]      req_key_code,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [kle_pkg::STAT_W-1:0]     rsp_status,
   output logic [kle_pkg::KEY_W-1:0]      rsp_char_out,
   output logic [kle_pkg::POS_W-1:0]      rsp_cursor_index,
   output logic [kle_pkg::COL_W-1:0]      rsp_cursor_column,
   output logic                           rsp_is_last,
   input  logic                           csr_wr_en,
   input  logic [kle_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kle_pkg::KEY_W-1:0]      csr_wdata
);
   import kle_pkg::*;

   csr_type          csr_ff, csr_in;
   alu_req_type      alu_req;
   alu_rsp_type      alu_rsp;
   ram_wr_type       ram_wr;
   logic             ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [KEY_W-1:0] ram_rd_data;
   push_type         push;
   logic             rsp_free;

   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff;
   logic [KEY_W-1:0] rsp_char_ff;
   logic [POS_W-1:0] rsp_cursor_ff;
   logic [COL_W-1:0] rsp_column_ff;
   logic             rsp_last_ff;

   always_comb begin
      csr_in = csr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_RANGE_LOW:    csr_in.range_low    = csr_wdata;
            CSR_RANGE_HIGH:   csr_in.range_high   = csr_wdata;
            CSR_START_COLUMN: csr_in.start_column = csr_wdata;
            default:          csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.range_low    <= RANGE_LOW_RESET;
         csr_ff.range_high   <= RANGE_HIGH_RESET;
         csr_ff.start_column <= START_COLUMN_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   kle_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   kle_line_ram u_line_ram (
      .clock   (clock),
      .ram_wr  (ram_wr),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   kle_sequencer u_sequencer (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_key_code (req_key_code),
      .req_ready    (req_ready),
      .csr          (csr_ff),
      .alu_req      (alu_req),
      .alu_rsp      (alu_rsp),
      .ram_wr       (ram_wr),
      .ram_rd_en    (ram_rd_en),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data),
      .rsp_free     (rsp_free),
      .push         (push)
   );

   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = push.load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.load) begin
         rsp_status_ff <= push.status;
         rsp_char_ff   <= push.char_out;
         rsp_cursor_ff <= push.cursor_index;
         rsp_column_ff <= push.cursor_column;
         rsp_last_ff   <= push.is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_char_out      = rsp_char_ff;
   assign rsp_cursor_index  = rsp_cursor_ff;
   assign rsp_cursor_column = rsp_column_ff;
   assign rsp_is_last       = rsp_last_ff;

endmodule

// File: hw/rtl/kle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_checker
// Port-level checks of the keystroke line editor, bound to its top level.
// ----------------------------------------------------------------------------
module kle_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [kle_pkg::STAT_W-1:0]    rsp_status,
   input logic [kle_pkg::KEY_W-1:0]     rsp_char_out,
   input logic [kle_pkg::POS_W-1:0]     rsp_cursor_index,
   input logic                          rsp_is_last
);
   import kle_pkg::*;

   // The editor works on one item at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("editor took a second item while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
         && $stable(rsp_char_out) && $stable(rsp_cursor_index)))
      else $error("stalled result changed");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_index <= POS_W'(LINE_DEPTH)))
      else $error("cursor beyond line capacity");

   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_last == (rsp_status != ST_LINE_CHAR)))
      else $error("last flag does not match status");

   a_char_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_ACCEPTED) && (rsp_status != ST_LINE_CHAR))
         |-> (rsp_char_out == '0))
      else $error("character set on a result that carries none");

endmodule

bind keystroke_line_editor kle_checker u_kle_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_status       (rsp_status),
   .rsp_char_out     (rsp_char_out),
   .rsp_cursor_index (rsp_cursor_index),
   .rsp_is_last      (rsp_is_last)
);

// File: bench/tb_keystroke_line_editor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_keystroke_line_editor
// Self-checking bench for the keystroke line editor.
//
// Key codes are offered on the request channel and every accepted item is run
// through a local line editor model, which queues the results it expects.
// Each result taken from the response channel is compared field by field with
// the oldest queued one. Directed keys cover the edges of the line and the
// navigation codes; random lines of editing keys then run under several
// acceptance ranges and start columns, with random gaps and stalls on both
// sides and one long response hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_keystroke_line_editor;
   import kle_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int MAX_GAP      = 15;
   localparam int DRAIN_CYCLES = 2 * LINE_DEPTH + 16;
   localparam int HOLD_CYCLES  = 300;
   localparam int MAX_REPORTS  = 10;

   typedef struct {
      status_type         status;
      logic [KEY_W-1:0]   char_out;
      logic [POS_W-1:0]   cursor_index;
      logic [COL_W-1:0]   cursor_column;
      logic               is_last;
   } line_result_type;

   logic                 clock        = 1'b0;
   logic                 reset        = 1'b1;
   logic                 req_valid    = 1'b0;
   logic                 req_ready;
   logic [KEY_W-1:0]     req_key_code = '0;
   logic                 rsp_valid;
   logic                 rsp_ready    = 1'b0;
   logic [STAT_W-1:0]    rsp_status;
   logic [KEY_W-1:0]     rsp_char_out;
   logic [POS_W-1:0]     rsp_cursor_index;
   logic [COL_W-1:0]     rsp_cursor_column;
   logic                 rsp_is_last;
   logic                 csr_wr_en    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [KEY_W-1:0]     csr_wdata    = '0;

   logic [KEY_W-1:0]     line_buf [LINE_DEPTH];
   logic [POS_W-1:0]     cur_pos;
   logic [POS_W-1:0]     line_len;
   csr_type              editor_cfg;
   line_result_type      expected_results [$];

   bit                   sender_no_idle;
   bit                   rsp_no_idle;
   int                   rsp_hold_cycles;
   int                   error_count;
   int                   keys_sent;
   int                   results_checked;
   int                   lines_entered;
   int                   full_drops;
   int                   csr_writes;

   keystroke_line_editor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_key_code      (req_key_code),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_char_out      (rsp_char_out),
      .rsp_cursor_index  (rsp_cursor_index),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_is_last       (rsp_is_last),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void push_expected(status_type st, logic [KEY_W-1:0] ch, logic last);
      expected_results.push_back('{st, ch, cur_pos,
                                   COL_W'(editor_cfg.start_column) + COL_W'(cur_pos), last});
   endfunction

   function automatic void predict_key(logic [KEY_W-1:0] key);
      bit accept;
      accept = ((key >= editor_cfg.range_low) && (key <= editor_cfg.range_high)) ||
               key == KEY_DOT || key == KEY_SPACE;
      case (key)
         KEY_ENTER: begin
            cur_pos = '0;
            for (int i = 0; i < line_len; i++) push_expected(ST_LINE_CHAR, line_buf[i], 1'b0);
            line_len = '0;
            lines_entered++;
            push_expected(ST_LINE_END, '0, 1'b1);
         end
         KEY_ESCAPE: begin
            cur_pos  = '0;
            line_len = '0;
            push_expected(ST_ABORTED, '0, 1'b1);
         end
         KEY_LEFT: begin
            if (cur_pos > 0) cur_pos--;
            push_expected(ST_MOVED, '0, 1'b1);
         end
         KEY_RIGHT: begin
            if (cur_pos < line_len) cur_pos++;
            push_expected(ST_MOVED, '0, 1'b1);
         end
         KEY_HOME: begin
            cur_pos = '0;
            push_expected(ST_MOVED, '0, 1'b1);
         end
         KEY_END: begin
            cur_pos = line_len;
            push_expected(ST_MOVED, '0, 1'b1);
         end
         default: begin
            if (!accept) begin
               push_expected(ST_IGNORED, '0, 1'b1);
            end else if (cur_pos >= LINE_DEPTH) begin
               full_drops++;
               push_expected(ST_FULL, '0, 1'b1);
            end else begin
               line_buf[cur_pos] = key;
               if (cur_pos == line_len) line_len++;
               cur_pos++;
               push_expected(ST_ACCEPTED, key, 1'b1);
            end
         end
      endcase
   endfunction

   function automatic logic [KEY_W-1:0] pick_char();
      logic [KEY_W-1:0] ch;
      logic [KEY_W-1:0] cand;
      ch = ($urandom_range(0, 1) != 0) ? KEY_DOT : KEY_SPACE;
      if (editor_cfg.range_low <= editor_cfg.range_high) begin
         for (int n = 0; n < 8; n++) begin
            cand = KEY_W'($urandom_range(editor_cfg.range_high, editor_cfg.range_low));
            if (!(cand inside {KEY_ENTER, KEY_ESCAPE, KEY_LEFT, KEY_RIGHT, KEY_HOME,
                               KEY_END})) begin
               ch = cand;
               break;
            end
         end
      end
      return ch;
   endfunction

   function automatic logic [KEY_W-1:0] pick_edit_key();
      int r;
      logic [KEY_W-1:0] nav [4];
      nav = '{KEY_LEFT, KEY_RIGHT, KEY_HOME, KEY_END};
      r = $urandom_range(0, 99);
      if (r < 50) return pick_char();
      if (r < 58) return ($urandom_range(0, 1) != 0) ? KEY_DOT : KEY_SPACE;
      if (r < 75) return nav[$urandom_range(0, 3)];
      if (r < 80) return KEY_ENTER;
      if (r < 82) return KEY_ESCAPE;
      return KEY_W'($urandom_range(0, 255));
   endfunction

   task automatic send_key(input logic [KEY_W-1:0] key);
      int gap;
      gap = sender_no_idle ? 0 : $urandom_range(0, MAX_GAP);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_key_code <= key;
      do @(posedge clock); while (!req_ready);
      predict_key(key);
      keys_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [KEY_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_RANGE_LOW:    editor_cfg.range_low    = data;
         CSR_RANGE_HIGH:   editor_cfg.range_high   = data;
         CSR_START_COLUMN: editor_cfg.start_column = data;
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic apply_settings(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                                 input logic [KEY_W-1:0] col);
      drain_results();
      csr_write(CSR_RANGE_LOW, lo);
      csr_write(CSR_RANGE_HIGH, hi);
      csr_write(CSR_START_COLUMN, col);
      csr_write(CSR_UNUSED, KEY_W'($urandom_range(0, 255)));
   endtask

   task automatic send_random_line();
      int len;
      int r;
      sender_no_idle = ($urandom_range(0, 3) == 0);
      rsp_no_idle    = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45) : $urandom_range(0, 12);
      repeat (len) send_key(pick_edit_key());
      r = $urandom_range(0, 99);
      if (r < 80) send_key(KEY_ENTER);
      else if (r < 92) send_key(KEY_ESCAPE);
   endtask

   task automatic test_directed_keys();
      send_key(KEY_ESCAPE);
      send_key(KEY_ENTER);
      send_key(KEY_LEFT);
      send_key(KEY_RIGHT);
      send_key(RANGE_LOW_RESET);
      send_key(RANGE_HIGH_RESET);
      send_key(KEY_DOT);
      send_key(KEY_SPACE);
      send_key(8'd47);
      send_key(8'd58);
      send_key(8'd0);
      send_key(8'd255);
      send_key(KEY_HOME);
      send_key(KEY_HOME);
      send_key(KEY_END);
      send_key(KEY_END);
      send_key(KEY_LEFT);
      send_key(8'd53);
      send_key(KEY_ENTER);
   endtask

   task automatic test_navigation_codes();
      apply_settings(8'd0, 8'd255, 8'd0);
      send_key(KEY_ESCAPE);
      send_key(8'd65);
      send_key(KEY_HOME);
      send_key(KEY_END);
      send_key(KEY_LEFT);
      send_key(KEY_RIGHT);
      send_key(KEY_ENTER);
   endtask

   task automatic test_random_editing(input int target);
      int first;
      first = keys_sent;
      while (keys_sent - first < target) send_random_line();
      sender_no_idle = 1'b0;
      rsp_no_idle    = 1'b0;
   endtask

   task automatic test_full_line();
      apply_settings(RANGE_LOW_RESET, RANGE_HIGH_RESET, 8'd255);
      send_key(KEY_ESCAPE);
      repeat (LINE_DEPTH) send_key(pick_char());
      send_key(pick_char());
      send_key(KEY_HOME);
      send_key(pick_char());
      send_key(KEY_END);
      send_key(KEY_DOT);
      send_key(KEY_LEFT);
      send_key(pick_char());
      send_key(KEY_RIGHT);
      send_key(KEY_ENTER);
   endtask

   task automatic test_range_settings();
      logic [KEY_W-1:0] lo_list  [6];
      logic [KEY_W-1:0] hi_list  [6];
      logic [KEY_W-1:0] col_list [6];
      lo_list  = '{8'd0,   8'd255, 8'd200, 8'd65, 8'd0, 8'd0};
      hi_list  = '{8'd255, 8'd0,   8'd200, 8'd90, 8'd0, 8'd0};
      col_list = '{8'd255, 8'd0,   8'd128, 8'd37, 8'd0, 8'd0};
      for (int s = 4; s < 6; s++) begin
         lo_list[s]  = KEY_W'($urandom_range(0, 255));
         hi_list[s]  = KEY_W'($urandom_range(0, 255));
         col_list[s] = KEY_W'($urandom_range(0, 255));
      end
      for (int s = 0; s < 6; s++) begin
         apply_settings(lo_list[s], hi_list[s], col_list[s]);
         test_random_editing(25);
      end
   endtask

   task automatic test_backpressure();
      drain_results();
      rsp_hold_cycles = HOLD_CYCLES;
      sender_no_idle  = 1'b1;
      for (int i = 0; i < 40; i++) send_key((i % 8 == 7) ? KEY_ENTER : pick_edit_key());
      sender_no_idle = 1'b0;
   endtask

   always @(posedge clock) begin
      line_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            if (error_count < MAX_REPORTS)
               $display("unexpected result: status %0d char %0d index %0d column %0d last %0d",
                        rsp_status, rsp_char_out, rsp_cursor_index, rsp_cursor_column,
                        rsp_is_last);
            error_count++;
         end else begin
            exp_r = expected_results.pop_front();
            results_checked++;
            if (rsp_status !== exp_r.status || rsp_char_out !== exp_r.char_out ||
                rsp_cursor_index !== exp_r.cursor_index ||
                rsp_cursor_column !== exp_r.cursor_column || rsp_is_last !== exp_r.is_last) begin
               if (error_count < MAX_REPORTS)
                  $display("mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d %s",
                           exp_r.status, exp_r.char_out, exp_r.cursor_index,
                           exp_r.cursor_column, exp_r.is_last, rsp_status, rsp_char_out,
                           rsp_cursor_index, rsp_cursor_column, rsp_is_last,
                           "(status/char/index/column/last)");
               error_count++;
            end
         end
      end
   end

   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) stall = rsp_hold_cycles;
         else stall = rsp_no_idle ? 0 : $urandom_range(0, MAX_GAP);
         rsp_hold_cycles = 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready) && rsp_hold_cycles == 0);
         @(negedge clock);
      end
   end

   initial begin
      #4_000_000;
      $display("timeout with %0d results still expected", expected_results.size());
      $display("FAIL keystroke_line_editor");
      $finish;
   end

   initial begin
      cur_pos    = '0;
      line_len   = '0;
      editor_cfg = '{range_low: RANGE_LOW_RESET, range_high: RANGE_HIGH_RESET,
                     start_column: START_COLUMN_RESET};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_keys();
      test_random_editing(40);
      test_navigation_codes();
      test_full_line();
      test_range_settings();
      test_backpressure();
      drain_results();

      $display("Run covered %0d keys, %0d checked results, %0d entered lines, %0d full drops.",
               keys_sent, results_checked, lines_entered, full_drops);
      $display("It made %0d register writes over eight settings and saw %0d mismatches.",
               csr_writes, error_count);
      if (error_count == 0) $display("PASS keystroke_line_editor");
      else $display("FAIL keystroke_line_editor");
      $finish;
   end

endmodule
